>>> sv/msd_pkg.sv
// Shared types, register indexes and the Morse letter table for the sample decoder.
// No dependencies; used by msd_core and morse_sample_decoder.
package msd_pkg;

    localparam int CFG_W       = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int LETTER_W    = 7;
    localparam int SYM_BITS_W  = 4;
    localparam int SYM_LEN_W   = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DOT_MAX  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DASH_MAX = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_GAP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_GAP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_END = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] DOT_MAX_RST  = 6'd3;
    localparam logic [CFG_W-1:0] DASH_MAX_RST = 6'd9;
    localparam logic [CFG_W-1:0] CHAR_GAP_RST = 6'd4;
    localparam logic [CFG_W-1:0] WORD_GAP_RST = 6'd10;
    localparam logic [CFG_W-1:0] IDLE_END_RST = 6'd22;

    localparam logic [SYM_LEN_W-1:0] SYM_LEN_MAX  = 3'd4;
    localparam logic [SYM_LEN_W-1:0] SYM_OVERFLOW = 3'd5;
    localparam logic [LETTER_W-1:0]  LETTER_BASE  = 7'd65;
    localparam logic [LETTER_W-1:0]  LETTER_NONE  = 7'd0;

    typedef struct packed {
        logic [CFG_W-1:0] dot_max_run;
        logic [CFG_W-1:0] dash_max_run;
        logic [CFG_W-1:0] char_gap_min;
        logic [CFG_W-1:0] word_gap_min;
        logic [CFG_W-1:0] idle_end_run;
    } msd_cfg_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                word_end;
        logic                message_end;
    } msd_result_t;

    // Symbol bits: first symbol most significant, 0 dot, 1 dash
    function automatic logic [LETTER_W-1:0] morse_letter(
        input logic [SYM_LEN_W-1:0]  len,
        input logic [SYM_BITS_W-1:0] bits
    );
        logic [LETTER_W-1:0] ofs;
        logic                hit;
        hit = 1'b1;
        ofs = '0;
        case ({len, bits})
            {3'd2, 4'd1}:  ofs = 7'd0;   // A
            {3'd4, 4'd8}:  ofs = 7'd1;   // B
            {3'd4, 4'd10}: ofs = 7'd2;   // C
            {3'd3, 4'd4}:  ofs = 7'd3;   // D
            {3'd1, 4'd0}:  ofs = 7'd4;   // E
            {3'd4, 4'd2}:  ofs = 7'd5;   // F
            {3'd3, 4'd6}:  ofs = 7'd6;   // G
            {3'd4, 4'd0}:  ofs = 7'd7;   // H
            {3'd2, 4'd0}:  ofs = 7'd8;   // I
            {3'd4, 4'd7}:  ofs = 7'd9;   // J
            {3'd3, 4'd5}:  ofs = 7'd10;  // K
            {3'd4, 4'd4}:  ofs = 7'd11;  // L
            {3'd2, 4'd3}:  ofs = 7'd12;  // M
            {3'd2, 4'd2}:  ofs = 7'd13;  // N
            {3'd3, 4'd7}:  ofs = 7'd14;  // O
            {3'd4, 4'd6}:  ofs = 7'd15;  // P
            {3'd4, 4'd13}: ofs = 7'd16;  // Q
            {3'd3, 4'd2}:  ofs = 7'd17;  // R
            {3'd3, 4'd0}:  ofs = 7'd18;  // S
            {3'd1, 4'd1}:  ofs = 7'd19;  // T
            {3'd3, 4'd1}:  ofs = 7'd20;  // U
            {3'd4, 4'd1}:  ofs = 7'd21;  // V
            {3'd3, 4'd3}:  ofs = 7'd22;  // W
            {3'd4, 4'd9}:  ofs = 7'd23;  // X
            {3'd4, 4'd11}: ofs = 7'd24;  // Y
            {3'd4, 4'd12}: ofs = 7'd25;  // Z
            default:       hit = 1'b0;
        endcase
        return hit ? (LETTER_BASE + ofs) : LETTER_NONE;
    endfunction

endpackage

>>> sv/msd_core.sv
// Per-sample decode state (run counters, symbol shift register) and its next-state logic.
// Depends on msd_pkg.
module msd_core #(
    parameter int RUN_COUNTER_BITS = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 line_sample,
    input  msd_pkg::msd_cfg_t    cfg,
    output logic                 res_valid,
    output msd_pkg::msd_result_t res
);
    import msd_pkg::*;

    localparam int RW    = RUN_COUNTER_BITS;
    localparam int CMP_W = (RW > CFG_W) ? RW : CFG_W;
    localparam logic [RW-1:0] RUN_MAX = {RW{1'b1}};
    localparam logic [RW-1:0] RUN_ONE = {{(RW-1){1'b0}}, 1'b1};

    logic                  active_reg, active_next;
    logic [RW-1:0]         mark_reg, mark_next;
    logic [RW-1:0]         gap_reg, gap_next;
    logic [SYM_BITS_W-1:0] bits_reg, bits_next;
    logic [SYM_LEN_W-1:0]  len_reg, len_next;

    logic [SYM_BITS_W-1:0] sym_bits;
    logic [SYM_LEN_W-1:0]  sym_len;
    logic [RW-1:0]         gap_inc;
    logic                  append, dash;
    logic [CMP_W-1:0]      mark_x, gap_x, gap_inc_x;

    assign mark_x    = CMP_W'(mark_reg);
    assign gap_x     = CMP_W'(gap_reg);
    assign gap_inc   = (gap_reg == RUN_MAX) ? gap_reg : gap_reg + RUN_ONE;
    assign gap_inc_x = CMP_W'(gap_inc);

    // Mark run classification when a gap sample closes it
    always_comb
    begin
        append = 1'b0;
        dash   = 1'b0;
        if (mark_reg != '0)
        begin
            if (mark_x <= CMP_W'(cfg.dot_max_run))
                append = 1'b1;
            else if (mark_x <= CMP_W'(cfg.dash_max_run))
            begin
                append = 1'b1;
                dash   = 1'b1;
            end
        end
        sym_bits = bits_reg;
        sym_len  = len_reg;
        if (append)
        begin
            if (len_reg < SYM_LEN_MAX)
            begin
                sym_bits = {bits_reg[SYM_BITS_W-2:0], dash};
                sym_len  = len_reg + 3'd1;
            end
            else
                sym_len = SYM_OVERFLOW;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        mark_next   = mark_reg;
        gap_next    = gap_reg;
        bits_next   = bits_reg;
        len_next    = len_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (step)
        begin
            if (!active_reg)
            begin
                if (line_sample)
                begin
                    active_next = 1'b1;
                    mark_next   = RUN_ONE;
                    gap_next    = '0;
                end
            end
            else if (line_sample)
            begin
                if (gap_reg != '0)
                begin
                    if (gap_x >= CMP_W'(cfg.char_gap_min))
                    begin
                        res_valid       = 1'b1;
                        res.letter      = morse_letter(len_reg, bits_reg);
                        res.word_end    = (gap_x >= CMP_W'(cfg.word_gap_min));
                        res.message_end = 1'b0;
                        bits_next       = '0;
                        len_next        = '0;
                    end
                    gap_next = '0;
                end
                if (mark_reg != RUN_MAX)
                    mark_next = mark_reg + RUN_ONE;
            end
            else
            begin
                mark_next = '0;
                bits_next = sym_bits;
                len_next  = sym_len;
                gap_next  = gap_inc;
                if (gap_inc_x >= CMP_W'(cfg.idle_end_run))
                begin
                    // end of message: flush pending letter and go idle
                    res_valid       = 1'b1;
                    res.letter      = morse_letter(sym_len, sym_bits);
                    res.word_end    = 1'b1;
                    res.message_end = 1'b1;
                    active_next     = 1'b0;
                    gap_next        = '0;
                    bits_next       = '0;
                    len_next        = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            mark_reg   <= '0;
            gap_reg    <= '0;
            bits_reg   <= '0;
            len_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            mark_reg   <= mark_next;
            gap_reg    <= gap_next;
            bits_reg   <= bits_next;
            len_reg    <= len_next;
        end
    end

endmodule

>>> sv/morse_sample_decoder.sv
// Morse sample decoder top level: configuration registers, decode core, output skid stage.
// Depends on msd_pkg and msd_core.
//
//  channel   direction  handshake            payload
//  input     in         in_valid/in_ready    line_sample
//  result    out        out_valid/out_ready  letter, word_end, message_end
//  config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// One sample per cycle while in_ready is high: a transfer updates the run counters and
// symbol register on that edge; a letter goes to the result register, or to skid if held.
// A second result register (skid) lets input transfers continue for one letter
// while out_ready is low; in_ready drops only when both are full.
// Reset (rst_n, async, active low) clears the decoder to idle, empties both
// result registers and loads the register defaults.
module morse_sample_decoder #(
    parameter int RUN_COUNTER_BITS = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                line_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [msd_pkg::LETTER_W-1:0]        letter,
    output logic                                word_end,
    output logic                                message_end,
    input  logic                                cfg_we,
    input  logic [msd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [msd_pkg::CFG_W-1:0]           cfg_data
);
    import msd_pkg::*;

    msd_cfg_t    cfg_reg;
    logic        step;
    logic        res_valid;
    msd_result_t res;

    logic        out_valid_reg, skid_valid_reg;
    msd_result_t out_data_reg, skid_data_reg;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_max_run  <= DOT_MAX_RST;
            cfg_reg.dash_max_run <= DASH_MAX_RST;
            cfg_reg.char_gap_min <= CHAR_GAP_RST;
            cfg_reg.word_gap_min <= WORD_GAP_RST;
            cfg_reg.idle_end_run <= IDLE_END_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DOT_MAX:  cfg_reg.dot_max_run  <= cfg_data;
                CFG_DASH_MAX: cfg_reg.dash_max_run <= cfg_data;
                CFG_CHAR_GAP: cfg_reg.char_gap_min <= cfg_data;
                CFG_WORD_GAP: cfg_reg.word_gap_min <= cfg_data;
                CFG_IDLE_END: cfg_reg.idle_end_run <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input side stalls only when a letter already sits in the skid register
    assign in_ready = !skid_valid_reg;
    assign step     = in_valid && in_ready;

    msd_core #(
        .RUN_COUNTER_BITS(RUN_COUNTER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .line_sample(line_sample),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register plus skid: skid fills only when the result register is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            if (res_valid)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (res_valid)
                skid_data_reg <= res;
        end
        else if (skid_valid_reg)
            out_data_reg <= skid_data_reg;
        else if (res_valid)
            out_data_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign letter      = out_data_reg.letter;
    assign word_end    = out_data_reg.word_end;
    assign message_end = out_data_reg.message_end;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a letter while result register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without a stalled result");

    a_msg_end_word_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.message_end) |-> out_data_reg.word_end)
        else $error("message end without word end");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.letter == LETTER_NONE ||
                           (out_data_reg.letter >= LETTER_BASE &&
                            out_data_reg.letter <= LETTER_BASE + 7'd25)))
        else $error("letter outside A..Z");
`endif

endmodule
